### sv/cswf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswf_pkg
// Shared types and constants of the clock-counter sliding-window filter.
// ----------------------------------------------------------------------------
package cswf_pkg;

  localparam int unsigned DEF_TABLE_SIZE = 65536;  // counters in the table
  localparam int unsigned MAX_HASHES     = 8;      // position words per item
  localparam int unsigned HASH_IW        = $clog2(MAX_HASHES);
  localparam int unsigned HASH_CW        = 4;      // width of hash_count
  localparam int unsigned CNT_W          = 16;     // counter width
  localparam int unsigned POS_W          = 16;     // position word width
  localparam int unsigned AMT_W          = 24;     // sweep_amount width
  localparam int unsigned CFG_DW         = 24;     // config data width
  localparam int unsigned CFG_AW         = 2;      // config index width

  localparam logic [HASH_CW-1:0] HASH_COUNT_RST = HASH_CW'(3);
  localparam logic [CNT_W-1:0]   CLOCK_MAX_RST  = CNT_W'(15);
  localparam logic [AMT_W-1:0]   SWEEP_AMT_RST  = '0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_SWEEP  = 2'd2
  } op_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_HASH_COUNT = 2'd0,
    CFG_CLOCK_MAX  = 2'd1,
    CFG_SWEEP_AMT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_INSERT = 5'b00100,
    S_QUERY  = 5'b01000,
    S_SWEEP  = 5'b10000
  } state_e;

endpackage

### sv/clock_sketch_window_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_sketch_window_filter
// Sliding-window Bloom filter of clock counters held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | operation_i, position_0_i .. position_7_i
//  result   | done_o (1 cycle)   | is_member_o, sweep_pointer_o
//  config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
//  Insert writes and query reads one counter per position word, for
//  hash_count words capped at 8; sweep ages every counter. A zero hash
//  count on insert or query, or an unknown operation, ends with no RAM
//  access. The single RAM port pair gives one counter read and one write
//  per cycle. After reset a clearing pass writes every counter to zero
//  with busy high; config writes are taken meanwhile. The result strobe
//  cannot be held off; a new word is accepted in the cycle its
//  predecessor's result is shown. TABLE_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module clock_sketch_window_filter
  import cswf_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [POS_W-1:0]  position_0_i,
  input  logic [POS_W-1:0]  position_1_i,
  input  logic [POS_W-1:0]  position_2_i,
  input  logic [POS_W-1:0]  position_3_i,
  input  logic [POS_W-1:0]  position_4_i,
  input  logic [POS_W-1:0]  position_5_i,
  input  logic [POS_W-1:0]  position_6_i,
  input  logic [POS_W-1:0]  position_7_i,
  output logic              done_o,
  output logic              is_member_o,
  output logic [POS_W-1:0]  sweep_pointer_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int unsigned AW  = $clog2(TABLE_SIZE);
  localparam int unsigned DEC_W = AMT_W + 1;

  // configuration
  logic [HASH_CW-1:0] hash_count_q;
  logic [CNT_W-1:0]   clock_max_q;
  logic [AMT_W-1:0]   sweep_amt_q;

  // control
  state_e             state_q, state_d;
  logic [HASH_CW-1:0] used_q, used_d;
  logic [HASH_CW-1:0] k_q, k_d;
  logic [AW:0]        addr_q, addr_d;
  logic [AW-1:0]      sweep_idx_q, sweep_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic               wr_vld_q, wr_vld_d;
  logic [AW-1:0]      wr_addr_q, wr_addr_d;
  logic               member_q, member_d;
  logic               done_q, done_d;
  logic               is_member_q, is_member_d;
  logic [1:0]         op_q;
  logic [AW-1:0]      pos_q [MAX_HASHES];

  // memory
  logic [CNT_W-1:0]   ctab_q [TABLE_SIZE];
  logic [CNT_W-1:0]   rd_data_q;
  logic [AW-1:0]      mem_raddr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CNT_W-1:0]   mem_wdata;

  // aging datapath
  logic [AW+AMT_W-1:0] amt_ext;
  logic [AMT_W-1:0]    share;
  logic [AW-1:0]       rem;
  logic [AW-1:0]       offset;
  logic [DEC_W-1:0]    dec;
  logic [DEC_W-1:0]    cur_ext;
  logic [CNT_W-1:0]    aged;

  logic               accept;
  logic [HASH_CW-1:0] used_in;
  logic [POS_W-1:0]   pos_in [MAX_HASHES];

  assign pos_in[0] = position_0_i;
  assign pos_in[1] = position_1_i;
  assign pos_in[2] = position_2_i;
  assign pos_in[3] = position_3_i;
  assign pos_in[4] = position_4_i;
  assign pos_in[5] = position_5_i;
  assign pos_in[6] = position_6_i;
  assign pos_in[7] = position_7_i;

  assign accept  = start && !busy;
  assign used_in = (hash_count_q > HASH_CW'(MAX_HASHES)) ? HASH_CW'(MAX_HASHES)
                                                          : hash_count_q;

  // share = amount / size, rem = amount % size
  assign amt_ext = (AW+AMT_W)'(sweep_amt_q);
  assign share   = AMT_W'(amt_ext >> AW);
  assign rem     = amt_ext[AW-1:0];
  assign offset  = wr_addr_q - sweep_idx_q;
  assign dec     = DEC_W'(share) + DEC_W'(offset < rem);
  assign cur_ext = DEC_W'(rd_data_q);
  assign aged    = (cur_ext <= dec) ? '0 : CNT_W'(cur_ext - dec);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    k_d         = k_q;
    addr_d      = addr_q;
    sweep_idx_d = sweep_idx_q;
    rd_vld_d    = 1'b0;
    wr_vld_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    member_d    = member_q;
    done_d      = 1'b0;
    is_member_d = is_member_q;
    mem_raddr   = pos_q[k_q[HASH_IW-1:0]];
    mem_we      = 1'b0;
    mem_waddr   = pos_q[k_q[HASH_IW-1:0]];
    mem_wdata   = clock_max_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q[AW-1:0];
        mem_wdata = '0;
        addr_d    = addr_q + 1'b1;
        if (&addr_q[AW-1:0]) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          used_d   = used_in;
          k_d      = '0;
          addr_d   = '0;
          member_d = 1'b1;
          case (operation_i)
            OP_INSERT: begin
              if (used_in == '0) begin
                done_d      = 1'b1;
                is_member_d = 1'b0;
              end else begin
                state_d = S_INSERT;
              end
            end
            OP_QUERY: begin
              if (used_in == '0) begin
                done_d      = 1'b1;
                is_member_d = 1'b1;
              end else begin
                state_d = S_QUERY;
              end
            end
            OP_SWEEP: state_d = S_SWEEP;
            default: begin
              done_d      = 1'b1;
              is_member_d = 1'b0;
            end
          endcase
        end
      end
      S_INSERT: begin
        mem_we = 1'b1;
        k_d    = k_q + 1'b1;
        if (k_q + 1'b1 == used_q) begin
          state_d     = S_IDLE;
          done_d      = 1'b1;
          is_member_d = 1'b0;
        end
      end
      S_QUERY: begin
        // reads issue while k < used, data lands in the next cycle
        if (k_q != used_q) begin
          rd_vld_d = 1'b1;
          k_d      = k_q + 1'b1;
        end
        if (rd_vld_q && rd_data_q == '0) begin
          member_d = 1'b0;
        end
        if (k_q == used_q && !rd_vld_q) begin
          state_d     = S_IDLE;
          done_d      = 1'b1;
          is_member_d = member_q;
        end
      end
      S_SWEEP: begin
        // read entry a, write back entry a-1 aged
        mem_raddr = addr_q[AW-1:0];
        mem_waddr = wr_addr_q;
        mem_wdata = aged;
        mem_we    = wr_vld_q;
        if (!addr_q[AW]) begin
          wr_vld_d  = 1'b1;
          wr_addr_d = addr_q[AW-1:0];
          addr_d    = addr_q + 1'b1;
        end
        if (addr_q[AW] && !wr_vld_q) begin
          state_d     = S_IDLE;
          addr_d      = '0;
          sweep_idx_d = sweep_idx_q + rem;
          done_d      = 1'b1;
          is_member_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      used_q       <= '0;
      k_q          <= '0;
      addr_q       <= '0;
      sweep_idx_q  <= '0;
      rd_vld_q     <= 1'b0;
      wr_vld_q     <= 1'b0;
      wr_addr_q    <= '0;
      member_q     <= 1'b0;
      done_q       <= 1'b0;
      is_member_q  <= 1'b0;
      hash_count_q <= HASH_COUNT_RST;
      clock_max_q  <= CLOCK_MAX_RST;
      sweep_amt_q  <= SWEEP_AMT_RST;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      k_q         <= k_d;
      addr_q      <= addr_d;
      sweep_idx_q <= sweep_idx_d;
      rd_vld_q    <= rd_vld_d;
      wr_vld_q    <= wr_vld_d;
      wr_addr_q   <= wr_addr_d;
      member_q    <= member_d;
      done_q      <= done_d;
      is_member_q <= is_member_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HASH_COUNT: hash_count_q <= cfg_wdata_i[HASH_CW-1:0];
          CFG_CLOCK_MAX:  clock_max_q  <= cfg_wdata_i[CNT_W-1:0];
          CFG_SWEEP_AMT:  sweep_amt_q  <= cfg_wdata_i[AMT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // command word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      for (int i = 0; i < MAX_HASHES; i++) begin
        pos_q[i] <= AW'(pos_in[i]);
      end
    end
  end

  // counter RAM: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ctab_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= ctab_q[mem_raddr];
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign is_member_o     = is_member_q;
  assign sweep_pointer_o = POS_W'(sweep_idx_q);

  // ---------------------------------------------------------------------------
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result shown while a word is still in work");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("counter RAM written while idle");

  a_sweep_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && mem_we && !addr_q[AW]) |-> mem_waddr != mem_raddr)
    else $error("sweep writes the entry it reads");

  a_member_query_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && is_member_q) |-> op_q == OP_QUERY)
    else $error("membership flagged for a non-query word");

  a_ptr_moves_on_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweep_idx_q != $past(sweep_idx_q)) |-> done_q && op_q == OP_SWEEP)
    else $error("sweep pointer moved outside a sweep");

endmodule
